/* src/servo_valve_controller_assert.svh */
// Assertion macros shared by the valve controller RTL.
`ifndef SERVO_VALVE_CONTROLLER_ASSERT_SVH
`define SERVO_VALVE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SVC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SVC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/svc_pkg.sv */
// Shared types and constants of the valve servo controller.
`timescale 1ns / 1ps

package svc_pkg;

  typedef enum logic [2:0] {
    MODE_CLOSE   = 3'd0,
    MODE_OPEN    = 3'd1,
    MODE_TRY     = 3'd2,
    MODE_ERRPEND = 3'd3,
    MODE_ERROR   = 3'd4,
    MODE_REGUL   = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    OP_PROCESS    = 3'd0,
    OP_OPEN       = 3'd1,
    OP_CLOSE      = 3'd2,
    OP_ENABLE_TRY = 3'd3,
    OP_ERROR      = 3'd4,
    OP_REGULATE   = 3'd5,
    OP_SET_WINDOW = 3'd6
  } op_t;

  typedef enum logic {
    REG_CLOSE_TRIM = 1'b0,
    REG_OPEN_TRIM  = 1'b1
  } cfg_reg_t;

  localparam int unsigned TRY_STEPS_DEF = 5;

  localparam logic [31:0] STEP_TICKS  = 32'd50;
  localparam logic [31:0] ERROR_TICKS = 32'd3500;

  localparam logic [6:0]  TRIM_RESET  = 7'd50;
  localparam logic [11:0] WIDTH_RESET = 12'd2000;
  localparam logic [6:0]  OPEN_MAX    = 7'd100;

  // Pulse width end points: base + (mid - trim) * scale.
  localparam logic signed [12:0] LO_BASE    = 13'sd2000;
  localparam logic signed [12:0] HI_BASE    = 13'sd1275;
  localparam logic signed [12:0] TRIM_MID   = 13'sd50;
  localparam logic signed [12:0] TRIM_SCALE = 13'sd10;

  // Interpolation span and its reciprocal: floor(n / 99) = (n * RECIP) >> 25
  // for every numerator below 2^18.
  localparam logic [17:0] SPAN        = 18'd99;
  localparam logic [18:0] RECIP       = 19'd338934;
  localparam int unsigned RECIP_SHIFT = 25;

  typedef struct packed {
    mode_t       mode;
    logic        ret;       // mode to fall back to after try: 1 open, 0 close
    logic [7:0]  opening;
    logic [4:0]  step;
    logic [31:0] step_dl;
    logic [31:0] err_dl;
    logic [31:0] win_dl;
    logic [7:0]  att;
  } ctl_state_t;

  // Pulse width update request: new opening percent, already clipped.
  typedef struct packed {
    logic       upd;
    logic [6:0] v;
  } wreq_t;

endpackage

/* src/svc_ctrl.sv */
// Event decoder and mode state update of the valve servo controller.
`timescale 1ns / 1ps

module svc_ctrl import svc_pkg::*; #(
  parameter int unsigned TRY_STEPS = TRY_STEPS_DEF
) (
  input  op_t         op,
  input  logic [7:0]  value,
  input  logic        close_flag,
  input  logic [31:0] window_ticks,
  input  logic [31:0] now,
  input  ctl_state_t  cur,
  output ctl_state_t  nxt,
  output wreq_t       wreq,
  output logic        acc
);

  localparam logic [4:0] LAST_STEP = 5'(TRY_STEPS);

  typedef struct packed {
    ctl_state_t s;
    wreq_t      w;
    logic       acc;
  } work_t;

  function automatic wreq_t width_req(logic [7:0] a);
    wreq_t r;
    r.upd = 1'b1;
    r.v   = (a > 8'(OPEN_MAX)) ? OPEN_MAX : a[6:0];
    return r;
  endfunction

  function automatic logic [7:0] sat_inc(logic [7:0] a);
    return (a == 8'hFF) ? a : a + 8'd1;
  endfunction

  function automatic logic passed(logic [31:0] dl, logic [31:0] t);
    return (dl != 32'd0) && (dl < t);
  endfunction

  // Note the inverted fall-back: a try entered from open ends closed.
  function automatic work_t leave_try(work_t w);
    work_t r;
    r = w;
    if (r.s.ret) begin
      r.w         = width_req(8'd0);
      r.s.mode    = MODE_CLOSE;
      r.s.opening = 8'd0;
    end else begin
      r.s.mode = MODE_OPEN;
      r.w      = width_req(r.s.opening);
    end
    r.s.step = 5'd0;
    r.s.att  = sat_inc(r.s.att);
    return r;
  endfunction

  function automatic work_t do_open(work_t w, logic [7:0] v);
    work_t r;
    r = w;
    if (r.s.mode == MODE_CLOSE || r.s.mode == MODE_OPEN) begin
      r.s.mode    = MODE_OPEN;
      r.s.opening = v;
      r.w         = width_req(v);
      r.acc       = 1'b1;
    end else if (r.s.mode == MODE_TRY) begin
      r     = leave_try(r);
      r.acc = 1'b1;
    end
    return r;
  endfunction

  function automatic work_t do_close(work_t w);
    work_t r;
    r = w;
    if (r.s.mode == MODE_OPEN) begin
      r.w         = width_req(8'd0);
      r.s.mode    = MODE_CLOSE;
      r.s.opening = 8'd0;
      r.acc       = 1'b1;
    end else if (r.s.mode == MODE_TRY) begin
      r     = leave_try(r);
      r.acc = 1'b1;
    end
    return r;
  endfunction

  function automatic work_t try_tick(work_t w, logic [31:0] t);
    work_t r;
    r = w;
    if (r.s.step == 5'd0) begin
      r.s.step_dl = t + STEP_TICKS;
      r.s.step    = 5'd1;
      r.w         = width_req(r.s.opening + 8'd1);
    end else if (r.s.step < LAST_STEP) begin
      if (passed(r.s.step_dl, t)) begin
        r.s.step_dl = t + STEP_TICKS;
        r.s.step    = r.s.step + 5'd1;
        r.w         = width_req(r.s.opening + {r.s.step, 3'b000});
      end
    end else begin
      r.s.step_dl = 32'd0;
      r.s.step    = 5'd0;
      r.w         = width_req(r.s.opening);
      r.s.mode    = r.s.ret ? MODE_OPEN : MODE_CLOSE;
      r.s.att     = sat_inc(r.s.att);
    end
    return r;
  endfunction

  always_comb begin
    work_t w;
    w.s   = cur;
    w.w   = '0;
    w.acc = 1'b0;
    unique case (op)
      OP_PROCESS: begin
        if (value == 8'd0 && w.s.opening != 8'd0) begin
          w = do_close(w);
        end
        if (value != 8'd0 && value != w.s.opening) begin
          w = do_open(w, value);
        end
        case (w.s.mode)
          MODE_OPEN: begin
            w.s.opening = value;
            w.w         = width_req(value);
          end
          MODE_CLOSE: begin
            w.s.opening = 8'd0;
            w.w         = width_req(8'd0);
          end
          MODE_TRY: begin
            w = try_tick(w, now);
          end
          MODE_ERRPEND: begin
            if (w.s.err_dl != 32'd0) begin
              if (w.s.err_dl < now) begin
                w.s.mode = MODE_ERROR;
              end
            end else begin
              w.s.err_dl = now + ERROR_TICKS;
            end
          end
          default: begin
          end
        endcase
        if (passed(w.s.win_dl, now)) begin
          w.s.att    = 8'd0;
          w.s.win_dl = 32'd0;
        end
        // Open and close steps taken inside a process event are not reported.
        w.acc = 1'b0;
      end
      OP_OPEN: begin
        w = do_open(w, value);
      end
      OP_CLOSE: begin
        w = do_close(w);
      end
      OP_ENABLE_TRY: begin
        if (w.s.mode == MODE_OPEN || w.s.mode == MODE_CLOSE) begin
          w.s.ret  = (w.s.mode == MODE_OPEN);
          w.s.mode = MODE_TRY;
        end
      end
      OP_ERROR: begin
        if (close_flag) begin
          w.w = width_req(8'd0);
        end
        w.s.mode = MODE_ERRPEND;
      end
      OP_REGULATE: begin
        w.s.mode = MODE_REGUL;
        w.w      = width_req(value);
      end
      OP_SET_WINDOW: begin
        w.s.win_dl = now + window_ticks;
      end
      default: begin
      end
    endcase
    nxt  = w.s;
    wreq = w.w;
    acc  = w.acc;
  end

endmodule

/* src/svc_width.sv */
// Pulse width datapath: interpolation between trimmed end points and division by 99.
`timescale 1ns / 1ps

module svc_width import svc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        valid1,
  input  wreq_t       req,
  input  logic [6:0]  close_trim,
  input  logic [6:0]  open_trim,
  output logic [11:0] width
);

  logic signed [12:0] lo_s;
  logic signed [12:0] hi_s;
  logic [17:0]        lo99_r;
  logic signed [11:0] diff_r;
  logic signed [19:0] num_s;
  logic [17:0]        num_r;
  logic               upd2_r;
  logic [36:0]        prod;
  logic [11:0]        quo;
  logic [11:0]        width_r;

  // End points track trims; change trims only with the pipe empty (not enforced).
  assign lo_s = LO_BASE + (TRIM_MID - $signed({6'b0, close_trim})) * TRIM_SCALE;
  assign hi_s = HI_BASE + (TRIM_MID - $signed({6'b0, open_trim})) * TRIM_SCALE;

  always_ff @(posedge clk) begin
    lo99_r <= 18'($unsigned(lo_s)) * SPAN;
    diff_r <= 12'(hi_s - lo_s);
  end

  // num = lo*99 + (hi - lo)*v, which equals lo*(99 - v) + hi*v and stays positive.
  assign num_s = $signed({2'b00, lo99_r}) + 20'(diff_r) * 20'($signed({1'b0, req.v}));

  assign prod = 37'(num_r) * 37'(RECIP);
  assign quo  = 12'(prod >> RECIP_SHIFT);

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r <= num_s[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upd2_r  <= 1'b0;
      width_r <= WIDTH_RESET;
    end else if (adv) begin
      upd2_r <= valid1 && req.upd;
      if (upd2_r) begin
        width_r <= quo;
      end
    end
  end

  assign width = width_r;

endmodule

/* src/servo_valve_controller.sv */
// Top level of the valve servo controller: mode state, config registers and result pipe.
// Pipe: three register stages (valid bits v1_r to v3_r); results are offered from the last.
// Throughput: one request per cycle; the pipe holds whole while a finished result waits.
// Reset: rst_n is synchronous and active low; mode close, opening 0, width 2000, trims 50.
// No clearing pass follows reset: the block takes requests on the first cycle after it.
`timescale 1ns / 1ps
`include "servo_valve_controller_assert.svh"

module servo_valve_controller import svc_pkg::*; #(
  parameter int unsigned TRY_STEPS = TRY_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,  // value[7:0], close_flag[8], window_ticks[40:9],
                                 // now[72:41], zero fill[79:73]
  input  logic [2:0]  in_tuser,  // op[2:0]
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata, // pulse_width[11:0], mode[14:12], attempts[22:15],
                                 // accepted[23]
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);

  // Mode, attempt count and accepted flag of one result as it moves down the pipe.
  typedef struct packed {
    mode_t      mode;
    logic [7:0] att;
    logic       acc;
  } stat_t;

  ctl_state_t st_r;
  ctl_state_t st_nxt;
  wreq_t      wreq_nxt;
  logic       acc_nxt;

  logic [6:0] close_trim_r;
  logic [6:0] open_trim_r;

  logic       v1_r, v2_r, v3_r;
  stat_t      s1_r, s2_r, s3_r;
  wreq_t      wreq1_r;
  logic [11:0] width;

  logic       adv;
  logic       in_acc;
  op_t        op;

  // The whole pipe moves together; it only halts when a finished result is not taken.
  assign adv       = !v3_r || out_tready;
  assign in_tready = adv;
  assign in_acc    = in_tvalid && adv;
  assign op        = op_t'(in_tuser);

  // The mode logic is a single pass over the current state; each request sees
  // the state left by the one before it, so requests can follow back to back.
  svc_ctrl #(
    .TRY_STEPS(TRY_STEPS)
  ) u_ctrl (
    .op          (op),
    .value       (in_tdata[7:0]),
    .close_flag  (in_tdata[8]),
    .window_ticks(in_tdata[40:9]),
    .now         (in_tdata[72:41]),
    .cur         (st_r),
    .nxt         (st_nxt),
    .wreq        (wreq_nxt),
    .acc         (acc_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode    <= MODE_CLOSE;
      st_r.ret     <= 1'b0;
      st_r.opening <= 8'd0;
      st_r.step    <= 5'd0;
      st_r.step_dl <= 32'd0;
      st_r.err_dl  <= 32'd0;
      st_r.win_dl  <= 32'd0;
      st_r.att     <= 8'd0;
    end else if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  // Configuration registers. Writes are always taken; a trim change only shows
  // in the pulse width at the next request that updates it.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      close_trim_r <= TRIM_RESET;
      open_trim_r  <= TRIM_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CLOSE_TRIM: close_trim_r <= cfg_data;
        REG_OPEN_TRIM:  open_trim_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Pipe valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Pipe payload: status fields travel alongside the width computation.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r.mode <= st_nxt.mode;
      s1_r.att  <= st_nxt.att;
      s1_r.acc  <= acc_nxt;
      wreq1_r   <= wreq_nxt;
      s2_r      <= s1_r;
      s3_r      <= s2_r;
    end
  end

  // Stage two forms the interpolation numerator, stage three divides by 99 and
  // updates the held pulse width, so the width lines up with stage three.
  svc_width u_width (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .valid1    (v1_r),
    .req       (wreq1_r),
    .close_trim(close_trim_r),
    .open_trim (open_trim_r),
    .width     (width)
  );

  assign out_tvalid = v3_r;
  assign out_tdata  = {s3_r.acc, s3_r.att, s3_r.mode, width};

  // An acted-on open or close always leaves the valve open or closed.
  `SVC_ASSERT_IMPL(a_acc_mode, v3_r && s3_r.acc,
    s3_r.mode == MODE_OPEN || s3_r.mode == MODE_CLOSE, "accepted result in wrong mode")

  // The try step counter is clear whenever the valve is plainly open or closed.
  `SVC_ASSERT_IMPL(a_step_idle, st_r.mode == MODE_OPEN || st_r.mode == MODE_CLOSE,
    st_r.step == 5'd0, "try step set in open or close mode")

  // Once set, the error deadline is kept until reset.
  `SVC_ASSERT_NEXT(a_err_dl_kept, st_r.err_dl != 32'd0, $stable(st_r.err_dl),
    "error deadline changed after being set")

endmodule

/* dv/servo_valve_controller_tb.sv */
// Self-checking testbench for the valve servo controller: directed table, random events, scoreboard.
`timescale 1ns / 1ps

module servo_valve_controller_tb;
  import svc_pkg::*;

  // Event code 7 is not an operation; the block must report its state unchanged.
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int QUIET_LIMIT = 2000;
  localparam int N_ROWS      = 26;
  // Rows from here on enter error or regulation, which only a reset leaves.
  localparam int LATE_FIRST  = 19;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  value;
    logic        close_flag;
    logic [31:0] window;
    logic [31:0] now;
  } valve_req_t;

  // Same bit order as out_tdata, most significant field first.
  typedef struct packed {
    logic       accepted;
    logic [7:0] attempts;
    mode_t      mode;
    logic [11:0] pulse_width;
  } valve_status_t;

  typedef struct {
    logic [2:0]    op;
    logic [7:0]    value;
    logic          close_flag;
    logic [31:0]   window;
    logic [31:0]   now;
    bit            typed;
    valve_status_t want;
  } dir_row_t;

  localparam valve_status_t NO_WANT = '0;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [6:0]  cfg_data = '0;

  servo_valve_controller u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Predicted controller state, starting from its reset values.
  mode_t       st_mode       = MODE_CLOSE;
  logic        st_back_open  = 1'b0;
  logic [7:0]  st_opening    = 8'd0;
  logic [11:0] st_width      = WIDTH_RESET;
  logic [4:0]  st_step       = 5'd0;
  logic [31:0] st_step_dl    = '0;
  logic [31:0] st_err_dl     = '0;
  logic [31:0] st_win_dl     = '0;
  logic [7:0]  st_att        = 8'd0;
  logic [6:0]  st_close_trim = TRIM_RESET;
  logic [6:0]  st_open_trim  = TRIM_RESET;

  valve_status_t status_due [$];
  int          mismatch_count = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  int          quiet_cycles = 0;
  logic [31:0] tick_now = '0;

  dir_row_t dir_rows [0:N_ROWS-1] = '{
    // Reset state, unused code and a close that is ignored while closed.
    '{OP_PROCESS,    8'd0,   1'b0, 32'd0,   32'd10,  1'b1, '{1'b0, 8'd0, MODE_CLOSE, 12'd2000}},
    '{OP_UNUSED,     8'd255, 1'b1, '1,      32'd11,  1'b1, '{1'b0, 8'd0, MODE_CLOSE, 12'd2000}},
    '{OP_CLOSE,      8'd0,   1'b0, 32'd0,   32'd12,  1'b1, '{1'b0, 8'd0, MODE_CLOSE, 12'd2000}},
    // Opening above 100 percent is clipped; opening to zero gives the closed width.
    '{OP_OPEN,       8'd255, 1'b0, 32'd0,   32'd13,  1'b0, NO_WANT},
    '{OP_OPEN,       8'd0,   1'b0, 32'd0,   32'd14,  1'b1, '{1'b1, 8'd0, MODE_OPEN, 12'd2000}},
    '{OP_PROCESS,    8'd50,  1'b0, 32'd0,   32'd20,  1'b0, NO_WANT},
    '{OP_PROCESS,    8'd0,   1'b0, 32'd0,   32'd30,  1'b1, '{1'b0, 8'd0, MODE_CLOSE, 12'd2000}},
    '{OP_SET_WINDOW, 8'd0,   1'b0, 32'd100, 32'd40,  1'b1, '{1'b0, 8'd0, MODE_CLOSE, 12'd2000}},
    // A full try run from open: five steps, the window expiring on the way, then back.
    '{OP_OPEN,       8'd30,  1'b0, 32'd0,   32'd41,  1'b0, NO_WANT},
    '{OP_ENABLE_TRY, 8'd0,   1'b0, 32'd0,   32'd42,  1'b0, NO_WANT},
    '{OP_PROCESS,    8'd30,  1'b0, 32'd0,   32'd43,  1'b0, NO_WANT},
    '{OP_PROCESS,    8'd30,  1'b0, 32'd0,   32'd93,  1'b0, NO_WANT},
    '{OP_PROCESS,    8'd30,  1'b0, 32'd0,   32'd94,  1'b0, NO_WANT},
    '{OP_PROCESS,    8'd30,  1'b0, 32'd0,   32'd145, 1'b0, NO_WANT},
    '{OP_PROCESS,    8'd30,  1'b0, 32'd0,   32'd196, 1'b0, NO_WANT},
    '{OP_PROCESS,    8'd30,  1'b0, 32'd0,   32'd247, 1'b0, NO_WANT},
    '{OP_PROCESS,    8'd30,  1'b0, 32'd0,   32'd248, 1'b0, NO_WANT},
    // Try left early by a zero request, which closes.
    '{OP_ENABLE_TRY, 8'd0,   1'b0, 32'd0,   32'd250, 1'b0, NO_WANT},
    '{OP_PROCESS,    8'd0,   1'b0, 32'd0,   32'd300, 1'b0, NO_WANT},
    // Error arms its deadline on the first check and becomes final once it has passed.
    '{OP_ERROR,      8'd0,   1'b0, 32'd0,   32'd400,  1'b0, NO_WANT},
    '{OP_PROCESS,    8'd0,   1'b0, 32'd0,   32'd401,  1'b0, NO_WANT},
    '{OP_PROCESS,    8'd0,   1'b0, 32'd0,   32'd3901, 1'b0, NO_WANT},
    '{OP_PROCESS,    8'd0,   1'b0, 32'd0,   32'd3902, 1'b0, NO_WANT},
    '{OP_ERROR,      8'd0,   1'b1, 32'd0,   32'd3903, 1'b0, NO_WANT},
    '{OP_REGULATE,   8'd255, 1'b0, 32'd0,   32'd3904, 1'b0, NO_WANT},
    '{OP_SET_WINDOW, 8'd0,   1'b0, '1,      '1,       1'b0, NO_WANT}
  };

  // ---------------------------------------------------------------- predictor

  function automatic logic [11:0] width_for(input logic [7:0] pct);
    int v, lo, hi;
    v  = (pct > 8'd100) ? 100 : int'(pct);
    lo = 2000 + (50 - int'(st_close_trim)) * 10;
    hi = 1275 + (50 - int'(st_open_trim)) * 10;
    return 12'((lo * (99 - v) + hi * v) / 99);
  endfunction

  function automatic bit deadline_passed(input logic [31:0] dl, input logic [31:0] now);
    return dl != '0 && dl < now;
  endfunction

  function automatic void count_attempt();
    if (st_att != 8'd255) st_att = st_att + 8'd1;
  endfunction

  function automatic void quit_try();
    if (st_back_open) begin
      st_width   = width_for(8'd0);
      st_mode    = MODE_CLOSE;
      st_opening = 8'd0;
    end else begin
      st_mode  = MODE_OPEN;
      st_width = width_for(st_opening);
    end
    st_step = 5'd0;
    count_attempt();
  endfunction

  function automatic bit take_open(input logic [7:0] v);
    if (st_mode == MODE_CLOSE || st_mode == MODE_OPEN) begin
      st_mode    = MODE_OPEN;
      st_opening = v;
      st_width   = width_for(v);
      return 1'b1;
    end
    if (st_mode == MODE_TRY) begin
      quit_try();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit take_close();
    if (st_mode == MODE_OPEN) begin
      st_width   = width_for(8'd0);
      st_mode    = MODE_CLOSE;
      st_opening = 8'd0;
      return 1'b1;
    end
    if (st_mode == MODE_TRY) begin
      quit_try();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void advance_try(input logic [31:0] now);
    if (st_step == 5'd0) begin
      st_step_dl = now + STEP_TICKS;
      st_step    = 5'd1;
      st_width   = width_for(st_opening + 8'd1);
    end else if (st_step < TRY_STEPS_DEF) begin
      if (deadline_passed(st_step_dl, now)) begin
        st_step_dl = now + STEP_TICKS;
        st_step    = st_step + 5'd1;
        st_width   = width_for(st_opening + 8'(st_step) * 8'd8);
      end
    end else begin
      st_step_dl = '0;
      st_step    = 5'd0;
      st_width   = width_for(st_opening);
      st_mode    = st_back_open ? MODE_OPEN : MODE_CLOSE;
      count_attempt();
    end
  endfunction

  function automatic void apply_process(input logic [7:0] v, input logic [31:0] now);
    if (v == 8'd0 && st_opening != 8'd0) void'(take_close());
    if (v != 8'd0 && v != st_opening) void'(take_open(v));
    case (st_mode)
      MODE_OPEN: begin
        st_opening = v;
        st_width   = width_for(v);
      end
      MODE_CLOSE: begin
        st_opening = 8'd0;
        st_width   = width_for(8'd0);
      end
      MODE_TRY: advance_try(now);
      MODE_ERRPEND: begin
        // The error deadline is armed once and kept over later errors.
        if (st_err_dl != '0) begin
          if (st_err_dl < now) st_mode = MODE_ERROR;
        end else begin
          st_err_dl = now + ERROR_TICKS;
        end
      end
      default: ;
    endcase
    if (deadline_passed(st_win_dl, now)) begin
      st_att    = 8'd0;
      st_win_dl = '0;
    end
  endfunction

  function automatic valve_status_t predict_status(input valve_req_t r);
    logic acc;
    acc = 1'b0;
    case (r.op)
      OP_PROCESS:    apply_process(r.value, r.now);
      OP_OPEN:       acc = take_open(r.value);
      OP_CLOSE:      acc = take_close();
      OP_ENABLE_TRY: begin
        if (st_mode == MODE_OPEN || st_mode == MODE_CLOSE) begin
          st_back_open = (st_mode == MODE_OPEN);
          st_mode      = MODE_TRY;
        end
      end
      OP_ERROR: begin
        if (r.close_flag) st_width = width_for(8'd0);
        st_mode = MODE_ERRPEND;
      end
      OP_REGULATE: begin
        st_mode  = MODE_REGUL;
        st_width = width_for(r.value);
      end
      OP_SET_WINDOW: st_win_dl = r.now + r.window;
      default: ;
    endcase
    return '{acc, st_att, st_mode, st_width};
  endfunction

  // ---------------------------------------------------------------- driving

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_event(input valve_req_t r, input bit typed, input valve_status_t want);
    int gap;
    valve_status_t pred;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, r.now, r.window, r.close_flag, r.value};
    in_tuser  <= r.op;
    do @(posedge clk); while (!in_tready);
    pred = predict_status(r);
    status_due.push_back(typed ? want : pred);
    if (r.op != OP_UNUSED) items_sent++;
    @(negedge clk);
  endtask

  // Hold the sender off until every predicted status has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (status_due.size() != 0);
    burst_left = 0;
  endtask

  task automatic write_trims(input logic [6:0] close_trim, input logic [6:0] open_trim);
    cfg_valid <= 1'b1;
    cfg_index <= REG_CLOSE_TRIM;
    cfg_data  <= close_trim;
    do @(posedge clk); while (!cfg_ready);
    st_close_trim = close_trim;
    @(negedge clk);
    cfg_index <= REG_OPEN_TRIM;
    cfg_data  <= open_trim;
    do @(posedge clk); while (!cfg_ready);
    st_open_trim = open_trim;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_rows(input int first, input int last);
    valve_req_t r;
    for (int i = first; i < last; i++) begin
      r = '{dir_rows[i].op, dir_rows[i].value, dir_rows[i].close_flag,
            dir_rows[i].window, dir_rows[i].now};
      send_event(r, dir_rows[i].typed, dir_rows[i].want);
    end
  endtask

  // Ticks mostly creep forward so that step and window deadlines pass; now and then
  // they jump anywhere, often close to the wrap.
  task automatic advance_tick();
    if ($urandom_range(0, 60) == 0)
      tick_now = $urandom_range(0, 1) ? $urandom() : 32'hFFFF_FF00 + $urandom_range(0, 255);
    else
      tick_now = tick_now + $urandom_range(0, 70);
  endtask

  // Fields that the operation ignores still carry random bits.
  function automatic valve_req_t rand_req(input logic [2:0] op);
    valve_req_t r;
    r.op         = op;
    r.value      = 8'($urandom());
    r.close_flag = 1'($urandom());
    r.window     = $urandom();
    r.now        = tick_now;
    return r;
  endfunction

  function automatic logic [7:0] pick_percent();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd100;
      2:       return 8'd101;
      3:       return 8'd255;
      default: return 8'($urandom_range(1, 99));
    endcase
  endfunction

  // One short sequence among close, open and try; error and regulation stay out.
  task automatic normal_sequence();
    valve_req_t r;
    int n;
    logic [2:0] op;
    advance_tick();
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        r = rand_req(OP_ENABLE_TRY);
        send_event(r, 1'b0, NO_WANT);
        n = $urandom_range(1, 8);
        repeat (n) begin
          advance_tick();
          r = rand_req(OP_PROCESS);
          if ($urandom_range(0, 7) != 0) r.value = st_opening;
          send_event(r, 1'b0, NO_WANT);
        end
        if ($urandom_range(0, 2) == 0) begin
          r = rand_req($urandom_range(0, 1) ? OP_OPEN : OP_CLOSE);
          send_event(r, 1'b0, NO_WANT);
        end
      end
      3: begin
        r = rand_req(OP_OPEN);
        r.value = pick_percent();
        send_event(r, 1'b0, NO_WANT);
      end
      4: send_event(rand_req(OP_CLOSE), 1'b0, NO_WANT);
      5, 6: begin
        r = rand_req(OP_PROCESS);
        case ($urandom_range(0, 2))
          0:       r.value = 8'd0;
          1:       r.value = st_opening;
          default: r.value = pick_percent();
        endcase
        send_event(r, 1'b0, NO_WANT);
      end
      7: begin
        r = rand_req(OP_SET_WINDOW);
        if ($urandom_range(0, 4) != 0) r.window = $urandom_range(0, 600);
        send_event(r, 1'b0, NO_WANT);
      end
      8: begin
        op = 3'($urandom_range(0, 5));
        if (op >= OP_ERROR) op = op + 3'd2;
        send_event(rand_req(op), 1'b0, NO_WANT);
      end
      default: send_event(rand_req(OP_UNUSED), 1'b0, NO_WANT);
    endcase
  endtask

  initial begin : stimulus
    int target;
    logic [6:0] close_list [0:4];
    logic [6:0] open_list [0:4];
    close_list = '{7'd0, 7'd100, 7'd127, 7'd100, 7'($urandom_range(0, 127))};
    open_list  = '{7'd0, 7'd100, 7'd127, 7'd0,   7'($urandom_range(0, 127))};

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    run_rows(0, LATE_FIRST);
    tick_now = 32'd500;

    for (int p = 0; p < 5; p++) begin
      drain();
      write_trims(close_list[p], open_list[p]);
      target = items_sent + 180;
      if (p == 3) begin
        // Enter and leave try back to back with no process events, so no window
        // can clear the count and it runs into saturation.
        repeat (270) begin
          send_event(rand_req(OP_ENABLE_TRY), 1'b0, NO_WANT);
          send_event(rand_req($urandom_range(0, 1) ? OP_OPEN : OP_CLOSE), 1'b0, NO_WANT);
        end
        target = items_sent + 40;
      end
      while (items_sent < target) normal_sequence();
    end

    // Error and regulation last: from here every operation is fair game.
    drain();
    write_trims(7'd0, 7'd100);
    run_rows(LATE_FIRST, N_ROWS);
    tick_now = 32'd4000;
    target = items_sent + 120;
    while (items_sent < target) begin
      advance_tick();
      send_event(rand_req(3'($urandom_range(0, 7))), 1'b0, NO_WANT);
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("servo_valve_controller verification clean");
    else
      $display("servo_valve_controller verification failed");
    $finish;
  end

  // ---------------------------------------------------------------- receiving

  // Result sink: stretches of steady accept, random accept, sparse accept and a
  // stall followed by accept.
  initial begin : result_sink
    int style, stretch, hold;
    forever begin
      style   = $urandom_range(0, 3);
      stretch = $urandom_range(4, 40);
      hold    = $urandom_range(1, 12);
      for (int k = 0; k < stretch; k++) begin
        @(negedge clk);
        case (style)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          2:       out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= (k >= hold);
        endcase
      end
    end
  end

  always @(posedge clk) begin : status_check
    valve_status_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (status_due.size() == 0) begin
        $display("%0t: status %h arrived with none expected", $time, out_tdata);
        mismatch_count++;
      end else begin
        want = status_due.pop_front();
        if (got.pulse_width !== want.pulse_width) begin
          $display("%0t: pulse_width expected %0d got %0d", $time,
                   want.pulse_width, got.pulse_width);
          mismatch_count++;
        end
        if (got.mode !== want.mode) begin
          $display("%0t: mode expected %0d got %0d", $time, want.mode, got.mode);
          mismatch_count++;
        end
        if (got.attempts !== want.attempts) begin
          $display("%0t: attempts expected %0d got %0d", $time, want.attempts, got.attempts);
          mismatch_count++;
        end
        if (got.accepted !== want.accepted) begin
          $display("%0t: accepted expected %0d got %0d", $time, want.accepted, got.accepted);
          mismatch_count++;
        end
      end
    end
  end

  // Ends the run if no request, status or register write moves for too long.
  always @(posedge clk) begin : watchdog
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("servo_valve_controller verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
